// ===== hw/rtl/bpa_pkg.sv =====
// Shared constants, codes and helpers of the page bitmap allocator.
`default_nettype none
package bpa_pkg;

  localparam int PAGE_BITS = 12;
  localparam int PG_SIZE   = 1 << PAGE_BITS;
  localparam int MAX_PAGES = 4096;
  localparam int IDX_W     = $clog2(MAX_PAGES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int LOOP_W    = 24;
  localparam int BP_W      = 32 - PAGE_BITS;
  localparam int END_W     = 21;
  localparam int RNG_W     = 22;
  localparam int AREA_W    = 33 - PAGE_BITS;
  localparam int INCR_W    = 32 - PAGE_BITS;
  localparam int CFG_AW    = 3;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_RESERVE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_ZERO  = 2'd1,
    STAT_NOFIT = 2'd2
  } status_t;

  // register index codes, taken from paddr[2]
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_END  = 1'b1;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             wdata;
    logic [IDX_W-1:0] raddr;
  } map_req_t;

  // (x + incr - 1) & ~(incr - 1), same mask arithmetic for any incr
  function automatic logic [LOOP_W-1:0] round_up(input logic [LOOP_W-1:0] x,
                                                 input logic [INCR_W-1:0] incr);
    logic [LOOP_W-1:0] m;
    m = LOOP_W'(incr) - LOOP_W'(1);
    return (x + m) & ~m;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bitmap_page_allocator_core.sv =====
// Top level of the page bitmap allocator: request sequencer, scan and APB registers.
//
// Usage notes
//  - Request channel (in_*): mode, addr, size, align, goal. Taken when in_valid is
//    high and in_stall low; in_stall is low only while the sequencer is idle.
//  - Result channel (out_*): status and address, one result per request, held in
//    an output register until taken (out_valid high, out_stall low). A new request
//    may be taken while a result still waits; its own result then waits for it.
//  - APB port: region_base at 0x0, region_end_page at 0x4. Write only while idle.
//  - Reset: a clearing pass over all MAX_PAGES (4096) pages marks every page reserved;
//    requests are held off during it, register writes are taken.
//  - Free/reserve set up the page range, then mark each page touched. Allocate
//    sets up, then probes the bitmap page by page, checks each candidate run,
//    then marks any new pages taken. The bitmap's single read port sets the
//    pace: the worst case is two passes over all 4096 pages.
//  - One request is in work at a time.
`default_nettype none
module bitmap_page_allocator_core
  import bpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_mode,
  input  wire logic [31:0]       in_addr,
  input  wire logic [31:0]       in_size,
  input  wire logic [31:0]       in_align,
  input  wire logic [31:0]       in_goal,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_status,
  output logic [31:0]            out_address,
  // APB configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_CLR   = 19'h00002,
    S_A1    = 19'h00004,
    S_A2    = 19'h00008,
    S_LOOP  = 19'h00010,
    S_NF    = 19'h00020,
    S_RND   = 19'h00040,
    S_RCHK  = 19'h00080,
    S_CHKI  = 19'h00100,
    S_J     = 19'h00200,
    S_JR    = 19'h00400,
    S_INC   = 19'h00800,
    S_FAIL  = 19'h01000,
    S_FOUND = 19'h02000,
    S_PACK  = 19'h04000,
    S_PACK2 = 19'h08000,
    S_RNG   = 19'h10000,
    S_RNG2  = 19'h20000,
    S_DONE  = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [31:0]      region_base_r;
  logic [END_W-1:0] region_end_r;

  // request fields
  logic [1:0]  mode_r, mode_nxt;
  logic [31:0] addr_r, addr_nxt, size_r, size_nxt, align_r, align_nxt, goal_r, goal_nxt;

  // allocation setup
  logic [31:0]       am_r, am_nxt, psel_r, psel_nxt;
  logic [INCR_W-1:0] off_r, off_nxt, incr_r, incr_nxt;
  logic [CNT_W-1:0]  eidx_r, eidx_nxt;
  logic [AREA_W-1:0] area_r, area_nxt;
  logic [LOOP_W-1:0] pref_r, pref_nxt, i_r, i_nxt, j_r, j_nxt, end_r, end_nxt;

  // allocator state
  logic [31:0]      hit_mark_r, hit_mark_nxt;
  logic [IDX_W-1:0] last_page_r, last_page_nxt;
  logic [PAGE_BITS-1:0] last_fill_r, last_fill_nxt;

  // finishing
  logic        pack_r, pack_nxt;
  logic [32:0] poff_r, poff_nxt;
  logic [31:0] rest_r, rest_nxt;
  logic [1:0]  res_status_r, res_status_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;

  // write sweep
  logic [CNT_W-1:0] swp_r, swp_nxt, swp_end_r, swp_end_nxt;
  logic             wval_r, wval_nxt;
  logic [RNG_W-1:0] rng_lo_r, rng_lo_nxt, rng_hi_r, rng_hi_nxt;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_address_r;

  map_req_t map_req;
  logic     map_rdata;

  bpa_map_ram u_map (
    .clk   (clk),
    .req   (map_req),
    .rdata (map_rdata)
  );

  // region helpers
  logic [BP_W-1:0] bp;
  logic [31:0]     base32;
  assign bp     = region_base_r[31:PAGE_BITS];
  assign base32 = {bp, {PAGE_BITS{1'b0}}};

  // APB
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_END) ? {{(32-END_W){1'b0}}, region_end_r} : region_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
      region_end_r  <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == REG_BASE) region_base_r <= pwdata;
      else                      region_end_r  <= pwdata[END_W-1:0];
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // scratch for the datapath
  logic [31:0]       a_eff, bm, off_full, goal_rel;
  logic [END_W-1:0]  eidx_full;
  logic              goal_ok;
  logic [32:0]       pm;
  logic [LOOP_W-1:0] rnd;
  logic [12:0]       room;
  logic [31:0]       ret;
  logic [33:0]       sum34;
  logic [RNG_W-1:0]  bpx, lo, hi_abs, hi;
  logic [LOOP_W-1:0] ext_eidx;

  always_comb begin
    state_nxt        = state_r;
    mode_nxt         = mode_r;
    addr_nxt         = addr_r;
    size_nxt         = size_r;
    align_nxt        = align_r;
    goal_nxt         = goal_r;
    am_nxt           = am_r;
    psel_nxt         = psel_r;
    off_nxt          = off_r;
    incr_nxt         = incr_r;
    eidx_nxt         = eidx_r;
    area_nxt         = area_r;
    pref_nxt         = pref_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    end_nxt          = end_r;
    hit_mark_nxt     = hit_mark_r;
    last_page_nxt    = last_page_r;
    last_fill_nxt    = last_fill_r;
    pack_nxt         = pack_r;
    poff_nxt         = poff_r;
    rest_nxt         = rest_r;
    res_status_nxt   = res_status_r;
    res_addr_nxt     = res_addr_r;
    swp_nxt          = swp_r;
    swp_end_nxt      = swp_end_r;
    wval_nxt         = wval_r;
    rng_lo_nxt       = rng_lo_r;
    rng_hi_nxt       = rng_hi_r;

    a_eff     = (align_r == 32'd0) ? 32'd1 : align_r;
    bm        = base32 & am_r;
    off_full  = (bm != 32'd0) ? (a_eff - bm) : 32'd0;
    eidx_full = (region_end_r > {1'b0, bp}) ? (region_end_r - {1'b0, bp}) : '0;
    goal_rel  = goal_r - base32;
    goal_ok   = (goal_r != 32'd0) && (goal_r >= base32) &&
                ({1'b0, goal_r[31:PAGE_BITS]} < region_end_r);
    pm        = ({1'b0, psel_r} + {1'b0, am_r}) & ~{1'b0, am_r};
    rnd       = round_up((state_r == S_JR) ? j_r : i_r, incr_r);
    room      = (poff_r < 33'(PG_SIZE)) ? 13'(33'(PG_SIZE) - poff_r) : 13'd0;
    ret       = {last_page_r, {PAGE_BITS{1'b0}}} + poff_r[31:0] + base32;
    sum34     = {2'b0, addr_r} + {2'b0, size_r};
    bpx       = {{(RNG_W-BP_W){1'b0}}, bp};
    lo        = (rng_lo_r < bpx) ? '0 : (rng_lo_r - bpx);
    hi_abs    = (rng_hi_r > bpx + RNG_W'(MAX_PAGES)) ? (bpx + RNG_W'(MAX_PAGES)) : rng_hi_r;
    hi        = (hi_abs > bpx) ? (hi_abs - bpx) : '0;
    ext_eidx  = {{(LOOP_W-CNT_W){1'b0}}, eidx_r};

    unique case (state_r)
      S_CLR: begin
        swp_nxt = swp_r + CNT_W'(1);
        if (swp_r == CNT_W'(MAX_PAGES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt       = in_mode;
          addr_nxt       = in_addr;
          size_nxt       = in_size;
          align_nxt      = in_align;
          goal_nxt       = in_goal;
          res_status_nxt = STAT_DONE;
          res_addr_nxt   = '0;
          unique case (mode_t'(in_mode))
            MODE_ALLOC: begin
              if (in_size == 32'd0) begin
                res_status_nxt = STAT_ZERO;
                state_nxt      = S_DONE;
              end else begin
                am_nxt    = ((in_align == 32'd0) ? 32'd1 : in_align) - 32'd1;
                state_nxt = S_A1;
              end
            end
            MODE_FREE: begin
              if (in_addr < hit_mark_r) hit_mark_nxt = in_addr;
              state_nxt = S_RNG;
            end
            MODE_RESERVE: state_nxt = S_RNG;
            MODE_NONE:    state_nxt = S_DONE;
            default:      state_nxt = S_DONE;
          endcase
        end
      end
      S_A1: begin
        off_nxt  = off_full[31:PAGE_BITS];
        eidx_nxt = (eidx_full > END_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : eidx_full[CNT_W-1:0];
        if (goal_ok) psel_nxt = (hit_mark_r >= goal_rel) ? hit_mark_r : goal_rel;
        else         psel_nxt = '0;
        area_nxt  = AREA_W'(({1'b0, size_r} + 33'(PG_SIZE - 1)) >> PAGE_BITS);
        incr_nxt  = (align_r[31:PAGE_BITS] == '0) ? INCR_W'(1) : align_r[31:PAGE_BITS];
        state_nxt = S_A2;
      end
      S_A2: begin
        pref_nxt  = LOOP_W'(pm[32:PAGE_BITS]) + LOOP_W'(off_r);
        i_nxt     = LOOP_W'(pm[32:PAGE_BITS]) + LOOP_W'(off_r);
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        state_nxt = (i_r < ext_eidx) ? S_NF : S_FAIL;
      end
      S_NF: begin
        // linear search for the next free page
        if (!map_rdata) begin
          state_nxt = S_RND;
        end else if (i_r + LOOP_W'(1) >= ext_eidx) begin
          i_nxt     = ext_eidx;
          state_nxt = S_RND;
        end else begin
          i_nxt = i_r + LOOP_W'(1);
        end
      end
      S_RND: begin
        i_nxt     = rnd;
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        state_nxt = (i_r >= ext_eidx) ? S_INC : S_CHKI;
      end
      S_CHKI: begin
        if (map_rdata) begin
          state_nxt = S_INC;
        end else if (area_r == AREA_W'(1)) begin
          state_nxt = S_FOUND;
        end else begin
          end_nxt = i_r + LOOP_W'(area_r);
          j_nxt   = i_r + LOOP_W'(1);
          state_nxt = (i_r + LOOP_W'(1) >= ext_eidx) ? S_JR : S_J;
        end
      end
      S_J: begin
        if (map_rdata) begin
          state_nxt = S_JR;
        end else if (j_r + LOOP_W'(1) >= end_r) begin
          state_nxt = S_FOUND;
        end else begin
          j_nxt = j_r + LOOP_W'(1);
          if (j_r + LOOP_W'(1) >= ext_eidx) state_nxt = S_JR;
        end
      end
      S_JR: begin
        i_nxt     = rnd;
        state_nxt = S_INC;
      end
      S_INC: begin
        i_nxt     = i_r + LOOP_W'(incr_r);
        state_nxt = S_LOOP;
      end
      S_FAIL: begin
        // one retry from the aligned region start
        if (pref_r <= LOOP_W'(off_r)) begin
          res_status_nxt = STAT_NOFIT;
          state_nxt      = S_DONE;
        end else begin
          pref_nxt  = LOOP_W'(off_r);
          i_nxt     = LOOP_W'(off_r);
          state_nxt = S_LOOP;
        end
      end
      S_FOUND: begin
        hit_mark_nxt = {{(32-PAGE_BITS-IDX_W){1'b0}}, i_r[IDX_W-1:0], {PAGE_BITS{1'b0}}};
        pack_nxt = (am_r < 32'(PG_SIZE - 1)) && (last_fill_r != '0) &&
                   ({1'b0, last_page_r} + CNT_W'(1) == {1'b0, i_r[IDX_W-1:0]});
        poff_nxt = ({{(33-PAGE_BITS){1'b0}}, last_fill_r} + {1'b0, am_r}) & ~{1'b0, am_r};
        state_nxt = S_PACK;
      end
      S_PACK: begin
        res_status_nxt = STAT_DONE;
        if (pack_r) begin
          res_addr_nxt = ret;
          if ({19'b0, size_r} < {38'b0, room}) begin
            last_fill_nxt = poff_r[PAGE_BITS-1:0] + size_r[PAGE_BITS-1:0];
            state_nxt     = S_DONE;
          end else begin
            rest_nxt  = size_r - {19'b0, room};
            state_nxt = S_PACK2;
          end
        end else begin
          res_addr_nxt  = {{(32-PAGE_BITS-IDX_W){1'b0}}, i_r[IDX_W-1:0], {PAGE_BITS{1'b0}}}
                          + base32;
          last_page_nxt = IDX_W'(LOOP_W'(i_r[IDX_W-1:0]) + LOOP_W'(area_r) - LOOP_W'(1));
          last_fill_nxt = size_r[PAGE_BITS-1:0];
          swp_nxt       = {1'b0, i_r[IDX_W-1:0]};
          swp_end_nxt   = CNT_W'(LOOP_W'(i_r[IDX_W-1:0]) + LOOP_W'(area_r));
          wval_nxt      = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_PACK2: begin
        area_nxt      = AREA_W'(({1'b0, rest_r} + 33'(PG_SIZE - 1)) >> PAGE_BITS);
        last_page_nxt = IDX_W'(LOOP_W'(i_r[IDX_W-1:0])
                        + LOOP_W'(AREA_W'(({1'b0, rest_r} + 33'(PG_SIZE - 1)) >> PAGE_BITS))
                        - LOOP_W'(1));
        last_fill_nxt = rest_r[PAGE_BITS-1:0];
        swp_nxt       = {1'b0, i_r[IDX_W-1:0]};
        swp_end_nxt   = CNT_W'(LOOP_W'(i_r[IDX_W-1:0])
                        + LOOP_W'(AREA_W'(({1'b0, rest_r} + 33'(PG_SIZE - 1)) >> PAGE_BITS)));
        wval_nxt      = 1'b1;
        state_nxt     = S_DONE;
      end
      S_RNG: begin
        if (mode_r == MODE_FREE) begin
          rng_lo_nxt = RNG_W'(({1'b0, addr_r} + 33'(PG_SIZE - 1)) >> PAGE_BITS);
          rng_hi_nxt = RNG_W'(sum34 >> PAGE_BITS);
          wval_nxt   = 1'b0;
        end else begin
          rng_lo_nxt = RNG_W'(addr_r >> PAGE_BITS);
          rng_hi_nxt = RNG_W'((sum34 + 34'(PG_SIZE - 1)) >> PAGE_BITS);
          wval_nxt   = 1'b1;
        end
        state_nxt = S_RNG2;
      end
      S_RNG2: begin
        // empty range when the start lies at or past the clamped end
        swp_nxt     = (lo < hi) ? lo[CNT_W-1:0] : hi[CNT_W-1:0];
        swp_end_nxt = hi[CNT_W-1:0];
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // mark sweep first, then hand the result over
        if (swp_r < swp_end_r) begin
          swp_nxt = swp_r + CNT_W'(1);
        end else if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // bitmap port: sweep writes, read at the index probed next cycle
  always_comb begin
    map_req.we    = (state_r == S_CLR) || ((state_r == S_DONE) && (swp_r < swp_end_r));
    map_req.waddr = swp_r[IDX_W-1:0];
    map_req.wdata = (state_r == S_CLR) ? 1'b1 : wval_r;
    map_req.raddr = (state_nxt == S_J) ? j_nxt[IDX_W-1:0] : i_nxt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLR;
      swp_r          <= '0;
      swp_end_r      <= '0;
      hit_mark_r     <= '0;
      last_page_r    <= '0;
      last_fill_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      swp_r          <= swp_nxt;
      swp_end_r      <= swp_end_nxt;
      hit_mark_r     <= hit_mark_nxt;
      last_page_r    <= last_page_nxt;
      last_fill_r    <= last_fill_nxt;
      if ((state_r == S_DONE) && (state_nxt == S_IDLE)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    addr_r       <= addr_nxt;
    size_r       <= size_nxt;
    align_r      <= align_nxt;
    goal_r       <= goal_nxt;
    am_r         <= am_nxt;
    psel_r       <= psel_nxt;
    off_r        <= off_nxt;
    incr_r       <= incr_nxt;
    eidx_r       <= eidx_nxt;
    area_r       <= area_nxt;
    pref_r       <= pref_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    end_r        <= end_nxt;
    pack_r       <= pack_nxt;
    poff_r       <= poff_nxt;
    rest_r       <= rest_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    wval_r       <= wval_nxt;
    rng_lo_r     <= rng_lo_nxt;
    rng_hi_r     <= rng_hi_nxt;
    if ((state_r == S_DONE) && (state_nxt == S_IDLE)) begin
      out_status_r  <= res_status_r;
      out_address_r <= res_addr_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_address = out_address_r;

endmodule
`default_nettype wire

// ===== hw/rtl/bpa_map_ram.sv =====
// Page bitmap store: one bit per page, one write and one registered read per cycle.
`default_nettype none
module bpa_map_ram
  import bpa_pkg::*;
(
  input  wire logic     clk,
  input  wire map_req_t req,
  output logic          rdata
);

  logic mem [MAX_PAGES];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== bench/tb_bitmap_page_allocator_core.sv =====
// Testbench for the page bitmap allocator: directed and random requests, checked against a predictor.
module tb_bitmap_page_allocator_core;
  import bpa_pkg::*;

  localparam longint unsigned PG = 64'd4096;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] address;
  } alloc_result_t;

  typedef struct {
    mode_t       mode;
    logic [31:0] addr;
    logic [31:0] size;
    logic [31:0] align;
    logic [31:0] goal;
  } page_request_t;

  // Scoreboard: keeps its own copy of the page map and marks, and the queue of due results
  class page_scoreboard;
    bit [31:0]       region_base;
    bit [20:0]       region_end_page;
    bit              busy_map [0:MAX_PAGES-1];
    longint unsigned hit_mark;
    longint unsigned last_page;
    longint unsigned last_fill;
    alloc_result_t   due_results[$];
    int              errors;

    function new();
      region_base = 0;
      region_end_page = 0;
      foreach (busy_map[k]) busy_map[k] = 1'b1;
      hit_mark = 0;
      last_page = 0;
      last_fill = 0;
      errors = 0;
    endfunction

    function void set_region(logic idx, logic [31:0] val);
      if (idx == REG_BASE) region_base = val;
      else region_end_page = val[20:0];
    endfunction

    function bit busy(longint unsigned i);
      if (i >= MAX_PAGES) return 1'b1;
      return busy_map[i];
    endfunction

    function longint unsigned round_to(longint unsigned x, longint unsigned incr);
      return (x + incr - 1) & ~(incr - 1);
    endfunction

    function longint unsigned first_free(longint unsigned i, longint unsigned lim);
      for (; i < lim; i++)
        if (!busy(i)) return i;
      return lim;
    endfunction

    function void mark_pages(longint unsigned first_abs, longint unsigned end_abs, bit v);
      longint unsigned bp;
      longint unsigned i;
      bp = region_base >> PAGE_BITS;
      if (first_abs < bp) first_abs = bp;
      if (end_abs > bp + MAX_PAGES) end_abs = bp + MAX_PAGES;
      for (i = first_abs; i < end_abs; i++) busy_map[i - bp] = v;
    endfunction

    function void allocate(longint unsigned size, longint unsigned align,
                           longint unsigned goal, output alloc_result_t res);
      longint unsigned bp, base, eidx, a, am, off, pref, area, incr;
      longint unsigned i, j, start, poff, room, rest, ret;
      bit found;
      bp = region_base >> PAGE_BITS;
      base = bp << PAGE_BITS;
      eidx = (region_end_page > bp) ? region_end_page - bp : 0;
      a = (align != 0) ? align : 1;
      am = a - 1;
      found = 0;
      start = 0;
      res.status = STAT_DONE;
      res.address = '0;
      if (size == 0) begin
        res.status = STAT_ZERO;
        return;
      end
      if (eidx > MAX_PAGES) eidx = MAX_PAGES;
      off = ((base & am) != 0) ? (a - (base & am)) : 0;
      off = off >> PAGE_BITS;
      if (goal != 0 && goal >= base && (goal >> PAGE_BITS) < region_end_page) begin
        pref = goal - base;
        if (hit_mark >= pref) pref = hit_mark;
      end else begin
        pref = 0;
      end
      pref = ((pref + am) & ~am) >> PAGE_BITS;
      pref += off;
      area = (size + PG - 1) >> PAGE_BITS;
      incr = align >> PAGE_BITS;
      if (incr == 0) incr = 1;
      // first fit from the preferred page, then once more from the aligned region start
      forever begin
        i = pref;
        while (i < eidx) begin
          i = round_to(first_free(i, eidx), incr);
          if (!(i >= eidx || busy(i))) begin
            for (j = i + 1; j < i + area; j++)
              if (j >= eidx || busy(j)) break;
            if (j >= i + area) begin
              start = i;
              found = 1;
              break;
            end
            i = round_to(j, incr);
          end
          i += incr;
        end
        if (found || pref <= off) break;
        pref = off;
      end
      if (!found) begin
        res.status = STAT_NOFIT;
        return;
      end
      hit_mark = (start << PAGE_BITS) & 64'hffff_ffff;
      if (a < PG && last_fill != 0 && last_page + 1 == start) begin
        // pack into the tail of the previous allocation's last page
        poff = (last_fill + am) & ~am;
        room = (poff < PG) ? PG - poff : 0;
        ret = last_page * PG + poff + base;
        if (size < room) begin
          area = 0;
          last_fill = (poff + size) & (PG - 1);
        end else begin
          rest = size - room;
          area = (rest + PG - 1) >> PAGE_BITS;
          last_page = (start + area - 1) & 64'hffff_ffff;
          last_fill = rest & (PG - 1);
        end
      end else begin
        last_page = (start + area - 1) & 64'hffff_ffff;
        last_fill = size & (PG - 1);
        ret = start * PG + base;
      end
      for (i = start; i < start + area; i++)
        if (i < MAX_PAGES) busy_map[i] = 1'b1;
      res.address = ret[31:0];
    endfunction

    function void note_request(page_request_t r);
      alloc_result_t res;
      longint unsigned addr, size;
      addr = r.addr;
      size = r.size;
      res.status = STAT_DONE;
      res.address = '0;
      case (r.mode)
        MODE_ALLOC: allocate(size, r.align, r.goal, res);
        MODE_FREE: begin
          if (addr < hit_mark) hit_mark = addr;
          mark_pages((addr + PG - 1) >> PAGE_BITS, (addr + size) >> PAGE_BITS, 1'b0);
        end
        MODE_RESERVE:
          mark_pages(addr >> PAGE_BITS, (addr + size + PG - 1) >> PAGE_BITS, 1'b1);
        default: ;
      endcase
      due_results.push_back(res);
    endfunction

    task report(string msg);
      $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [1:0] status, logic [31:0] address);
      alloc_result_t exp_res;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result status=%0d address=%h", status, address));
      end else begin
        exp_res = due_results.pop_front();
        if (status !== exp_res.status)
          report($sformatf("status %0d, expected %0d", status, exp_res.status));
        if (address !== exp_res.address)
          report($sformatf("address %h, expected %h", address, exp_res.address));
      end
    endtask
  endclass

  // ---------------------------------------------------------------- signals
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [31:0] in_addr, in_size, in_align, in_goal;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [31:0] out_address;
  logic        psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  page_scoreboard sb;

  // idling knobs, percent per cycle; hold_left forces a long stall on the result side
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int          hold_left;

  bitmap_page_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_addr    (in_addr),
    .in_size    (in_size),
    .in_align   (in_align),
    .in_goal    (in_goal),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_address(out_address),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous cap: covers full-region scans, plus the clearing pass
  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random stall, or a forced hold-off while hold_left runs down
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // sample results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_address);
  end

  // ---------------------------------------------------------------- drivers
  // Offer one request; starts and ends just after a falling edge.
  task send_request(page_request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= r.mode;
    in_addr  <= r.addr;
    in_size  <= r.size;
    in_align <= r.align;
    in_goal  <= r.goal;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // APB write: setup cycle then access cycle
  task write_reg(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_region(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task set_region(logic [31:0] base, logic [31:0] end_page);
    write_reg(REG_BASE, base);
    write_reg(REG_END, end_page);
    @(negedge clk);
  endtask

  task send(mode_t m, logic [31:0] a, logic [31:0] s, logic [31:0] al, logic [31:0] g);
    page_request_t r;
    r.mode = m;
    r.addr = a;
    r.size = s;
    r.align = al;
    r.goal = g;
    send_request(r);
  endtask

  // random request aimed mostly inside the current region
  function page_request_t random_request();
    page_request_t r;
    logic [31:0] rbase;
    int unsigned npg, pick;
    rbase = sb.region_base & 32'hffff_f000;
    npg = (sb.region_end_page > (sb.region_base >> PAGE_BITS)) ?
          sb.region_end_page - (sb.region_base >> PAGE_BITS) : 0;
    if (npg > MAX_PAGES) npg = MAX_PAGES;
    pick = $urandom_range(99);
    r.addr = rbase + $urandom_range(0, npg) * 4096 +
             ($urandom_range(1) ? $urandom_range(0, 4095) : 0);
    r.goal = 0;
    r.align = 0;
    if (pick < 8) begin
      // noise: anything the fields allow
      r.mode = mode_t'($urandom_range(0, 3));
      r.addr = $urandom;
      r.size = $urandom;
      r.align = $urandom;
      r.goal = $urandom;
    end else if (pick < 11) begin
      r.mode = MODE_NONE;
      r.size = $urandom;
    end else if (pick < 38) begin
      r.mode = MODE_FREE;
      r.size = $urandom_range(1, npg / 2 + 1) * 4096 + $urandom_range(0, 4095);
    end else if (pick < 48) begin
      r.mode = MODE_RESERVE;
      r.size = $urandom_range(1, 3 * 4096);
    end else begin
      r.mode = MODE_ALLOC;
      r.size = $urandom_range(2) == 0 ? $urandom_range(1, 4095) :
               $urandom_range(0, 6) * 4096 + $urandom_range(1, 4095);
      case ($urandom_range(5))
        0: r.align = 0;
        1, 2: r.align = 32'd1 << $urandom_range(0, 11);
        3: r.align = 32'd1 << $urandom_range(12, 15);
        4: r.align = $urandom_range(1, 4095);
        default: r.align = $urandom_range(9) == 0 ? 32'h8000_0000 : 0;
      endcase
      if ($urandom_range(1))
        r.goal = rbase + $urandom_range(0, npg) * 4096 + $urandom_range(0, 4095);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- main
  initial begin
    int unsigned region_items [6];
    logic [31:0] region_bases [6];
    logic [31:0] region_ends [6];
    int n;
    sb = new();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_NONE;
    in_addr = '0;
    in_size = '0;
    in_align = '0;
    in_goal = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: small region at zero
    set_region(32'h0, 32'd64);
    send(MODE_ALLOC, 0, 32'd4096, 0, 0);                       // all reserved: no fit
    send(MODE_ALLOC, 0, 0, 0, 0);                              // zero-sized
    send(MODE_FREE, 0, 64 * 4096, 0, 0);
    send(MODE_ALLOC, 0, 32'd1, 0, 0);
    send(MODE_ALLOC, 0, 32'd100, 32'd8, 0);                    // packed into the tail
    send(MODE_ALLOC, 0, 32'd5000, 32'd16, 0);
    send(MODE_ALLOC, 0, 32'd4096, 32'h2000, 32'h1_0000);
    send(MODE_ALLOC, 0, 32'd4000, 32'd3, 0);                   // odd alignment
    send(MODE_ALLOC, 0, 32'd3000, 32'd2047, 0);                // packing offset past page end
    send(MODE_ALLOC, 0, 32'hffff_ffff, 0, 0);
    send(MODE_ALLOC, 0, 32'd1, 32'h8000_0000, 0);
    send(MODE_ALLOC, 0, 32'd1, 0, 32'hffff_ffff);              // goal outside region
    send(MODE_FREE, 32'h1800, 32'h3000, 0, 0);                 // partial pages at both ends
    send(MODE_RESERVE, 32'h3000, 32'd1, 0, 0);
    send(MODE_RESERVE, 32'hffff_f000, 32'hffff_ffff, 0, 0);    // wraps past the 32-bit top
    send(MODE_FREE, 32'hffff_ffff, 32'hffff_ffff, 0, 0);
    send(MODE_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(MODE_FREE, 32'h0000_2000, 32'h0002_0000, 0, 0);       // lowers the last-success mark
    send(MODE_ALLOC, 0, 32'd8192, 32'h1000, 32'h0000_3000);
    send(MODE_ALLOC, 0, 32'd10, 32'd4, 32'h0003_0000);
    wait_drained();

    region_bases = '{32'h0, 32'h0010_0000, 32'h1234_5abc, 32'hffff_f000, 32'h0, 32'h8000_0000};
    region_ends  = '{32'd64, 32'd556, 32'h1_23c5, 32'h10_0000, 32'd4096, 32'd0};
    region_items = '{30, 30, 24, 10, 12, 8};
    n = 0;
    for (int p = 0; p < 6; p++) begin
      set_region(region_bases[p], region_ends[p]);
      // open most of the region so allocations can land
      send(MODE_FREE, region_bases[p] & 32'hffff_f000, 32'h0100_0000, 0, 0);
      for (int k = 0; k < region_items[p]; k++) begin
        case ((n / 10) % 5)
          1: begin send_idle_pct = 75; stall_pct = 0;  end
          2: begin send_idle_pct = 0;  stall_pct = 75; end
          3: begin send_idle_pct = 33; stall_pct = 33; end
          default: begin send_idle_pct = 0; stall_pct = 0; end
        endcase
        if (n == 25) hold_left = 800;  // long hold-off while requests keep coming
        if (n == 60) wait_drained();   // sender pause until every result is back
        send_request(random_request());
        n++;
      end
      wait_drained();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    repeat (50) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
